// ===== rtl/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and the digit rule shared by the hex record parser modules.
// ----------------------------------------------------------------------------
package hrp_pkg;

	// Position within the record.
	localparam logic [2:0] POS_COUNT   = 3'd0;
	localparam logic [2:0] POS_ADDR_HI = 3'd1;
	localparam logic [2:0] POS_ADDR_LO = 3'd2;
	localparam logic [2:0] POS_TYPE    = 3'd3;
	localparam logic [2:0] POS_DATA    = 3'd4;
	localparam logic [2:0] POS_CSUM    = 3'd5;

	// Record types.
	localparam logic [7:0] TYPE_DATA      = 8'd0;
	localparam logic [7:0] TYPE_EOF       = 8'd1;
	localparam logic [7:0] TYPE_EXT_SEG   = 8'd2;
	localparam logic [7:0] TYPE_START_SEG = 8'd3;
	localparam logic [7:0] TYPE_EXT_LIN   = 8'd4;
	localparam logic [7:0] TYPE_START_LIN = 8'd5;

	// Summary status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_START_SEG   = 3'd1;
	localparam logic [2:0] ST_CHECKSUM    = 3'd2;
	localparam logic [2:0] ST_EOF_COUNT   = 3'd3;
	localparam logic [2:0] ST_SEGMENT     = 3'd4;
	localparam logic [2:0] ST_LINEAR      = 3'd5;
	localparam logic [2:0] ST_START_LIN   = 3'd6;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

	// Result kinds.
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] char_code;
		logic       record_start;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  rec_type;
		logic [7:0]  byte_count;
		logic [31:0] load_address;
		logic [2:0]  status;
		logic        accepted;
	} out_item_t;

	// Header fields and checksum gathered while a record is parsed.
	typedef struct packed {
		logic [7:0]  count;
		logic [15:0] addr;
		logic [7:0]  rec_type;
		logic [7:0]  sum;
		logic [31:0] first_bytes;
	} rec_state_t;

	// Digit rule of the file format, all in 8-bit wraparound; bad characters
	// simply fall through it.
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		v = c - 8'd48;
		if (v > 8'd9) begin
			v = v - 8'd7;
		end
		if (v > 8'd15) begin
			v = v - 8'd32;
		end
		return v;
	endfunction

endpackage

// ===== rtl/hrp_summary.sv =====
// ----------------------------------------------------------------------------
// hrp_summary
// Checks a finished record and forms its summary result.
// ----------------------------------------------------------------------------
module hrp_summary import hrp_pkg::*; (
	input  rec_state_t rec,
	input  logic [7:0] csum_byte,
	output out_item_t  summary
);

	logic [7:0]  total;
	logic [2:0]  st;
	logic [15:0] word;
	logic [31:0] addr;

	assign total = rec.sum + csum_byte;
	assign word  = rec.first_bytes[31:16];

	always_comb begin
		st = ST_OK;
		if (total != 8'd0) begin
			st = ST_CHECKSUM;
		end else begin
			case (rec.rec_type)
				TYPE_DATA: begin
					st = ST_OK;
				end
				TYPE_EOF: begin
					if (rec.count != 8'd0) st = ST_EOF_COUNT;
				end
				TYPE_EXT_SEG: begin
					// The segment must also leave the low three bits of its
					// low byte clear.
					if (rec.addr != 16'd0 || rec.count != 8'd2 ||
					    rec.first_bytes[18:16] != 3'd0) st = ST_SEGMENT;
				end
				TYPE_START_SEG: begin
					st = ST_START_SEG;
				end
				TYPE_EXT_LIN: begin
					if (rec.addr != 16'd0 || rec.count != 8'd2) st = ST_LINEAR;
				end
				TYPE_START_LIN: begin
					if (rec.addr != 16'd0 || rec.count != 8'd4) st = ST_START_LIN;
				end
				default: begin
					st = ST_UNSUPPORTED;
				end
			endcase
		end
	end

	always_comb begin
		addr = {16'd0, rec.addr};
		if (st == ST_OK) begin
			if (rec.rec_type == TYPE_EXT_SEG) begin
				addr = {12'd0, word, 4'd0};
			end else if (rec.rec_type == TYPE_EXT_LIN) begin
				addr = {word, 16'd0};
			end else if (rec.rec_type == TYPE_START_LIN) begin
				addr = rec.first_bytes;
			end
		end
	end

	always_comb begin
		summary              = '0;
		summary.kind         = KIND_SUMMARY;
		summary.rec_type     = rec.rec_type;
		summary.byte_count   = rec.count;
		summary.load_address = addr;
		summary.status       = st;
		summary.accepted     = (st == ST_OK) || (st == ST_START_SEG);
	end

endmodule

// ===== rtl/hrp_parse.sv =====
// ----------------------------------------------------------------------------
// hrp_parse
// Record state: pairs digits into bytes, tracks the field position, and gives
// a data byte or the record summary as each data or checksum byte completes.
// ----------------------------------------------------------------------------
module hrp_parse import hrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	logic        in_record_q;
	logic [2:0]  field_pos_q;
	logic        nibble_phase_q;
	logic [3:0]  high_nibble_q;
	logic [7:0]  data_seen_q;
	rec_state_t  rec_q;

	logic [7:0]  v;
	logic [7:0]  b;
	logic [7:0]  seen_next;
	logic        byte_done;
	out_item_t   summary;

	assign v         = digit_value(item.char_code);
	assign b         = {high_nibble_q, 4'd0} + v;
	assign seen_next = data_seen_q + 8'd1;
	assign byte_done = !item.record_start && in_record_q && nibble_phase_q;

	hrp_summary u_summary (
		.rec       (rec_q),
		.csum_byte (b),
		.summary   (summary)
	);

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (byte_done) begin
			if (field_pos_q == POS_DATA) begin
				res_valid      = 1'b1;
				res.kind       = KIND_DATA;
				res.data_byte  = b;
				res.byte_index = data_seen_q;
			end else if (field_pos_q == POS_CSUM) begin
				res_valid = 1'b1;
				res       = summary;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q    <= 1'b0;
			field_pos_q    <= POS_COUNT;
			nibble_phase_q <= 1'b0;
			high_nibble_q  <= 4'd0;
			data_seen_q    <= 8'd0;
			rec_q          <= '0;
		end else if (step) begin
			if (item.record_start) begin
				in_record_q    <= 1'b1;
				field_pos_q    <= POS_COUNT;
				nibble_phase_q <= 1'b0;
				high_nibble_q  <= 4'd0;
				data_seen_q    <= 8'd0;
				rec_q          <= '0;
			end else if (in_record_q) begin
				if (!nibble_phase_q) begin
					high_nibble_q  <= v[3:0];
					nibble_phase_q <= 1'b1;
				end else begin
					nibble_phase_q <= 1'b0;
					case (field_pos_q)
						POS_COUNT: begin
							rec_q.count <= b;
							rec_q.sum   <= rec_q.sum + b;
							field_pos_q <= POS_ADDR_HI;
						end
						POS_ADDR_HI: begin
							rec_q.addr[15:8] <= b;
							rec_q.sum        <= rec_q.sum + b;
							field_pos_q      <= POS_ADDR_LO;
						end
						POS_ADDR_LO: begin
							rec_q.addr[7:0] <= b;
							rec_q.sum       <= rec_q.sum + b;
							field_pos_q     <= POS_TYPE;
						end
						POS_TYPE: begin
							rec_q.rec_type <= b;
							rec_q.sum      <= rec_q.sum + b;
							field_pos_q    <= (rec_q.count == 8'd0) ? POS_CSUM : POS_DATA;
						end
						POS_DATA: begin
							rec_q.sum <= rec_q.sum + b;
							// Only the first four data bytes are kept, first byte on top.
							if (data_seen_q < 8'd4) begin
								case (data_seen_q[1:0])
									2'd0:    rec_q.first_bytes[31:24] <= b;
									2'd1:    rec_q.first_bytes[23:16] <= b;
									2'd2:    rec_q.first_bytes[15:8]  <= b;
									default: rec_q.first_bytes[7:0]   <= b;
								endcase
							end
							data_seen_q <= seen_next;
							if (seen_next == rec_q.count) field_pos_q <= POS_CSUM;
						end
						POS_CSUM: begin
							in_record_q <= 1'b0;
						end
						default: begin
							in_record_q <= 1'b0;
						end
					endcase
				end
			end
		end
	end

endmodule

// ===== rtl/hex_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// hex_record_parser_unit
// Parses Intel HEX record text one character per transaction, emitting data
// bytes as they are decoded and a checked summary after each checksum.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload    | Transaction
//  char    | in        | in_item_t  | one record character
//  res     | out       | out_item_t | one data byte or one record summary
//
// One character is taken every cycle while char_ready is high. A character
// is held in an input register, decoded against the record state as it
// advances, and its result (if any) is registered in the output register.
// When the output register is full and not being taken, an occupied input
// register holds and char_ready drops. Reset clears the record state and
// both valid flags; no record is open after reset.
module hex_record_parser_unit import hrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;
	logic      advance;
	logic      dec_valid;
	out_item_t dec_item;

	assign advance    = valid_s1 && (!valid_s2 || res_ready);
	assign char_ready = !valid_s1 || advance;
	assign res_valid  = valid_s2;
	assign res_item   = item_s2;

	hrp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (dec_valid),
		.res       (dec_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= dec_valid;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec_valid) begin
			item_s2 <= dec_item;
		end
	end

endmodule
